### rtl/rhh_pkg.sv
// shared types and constants for the heading hold motor mixer
package rhh_pkg;

   // field widths
   localparam int unsigned PULSE_W = 12;
   localparam int unsigned ANGLE_W = 9;
   localparam int unsigned GAIN_W  = 7;
   localparam int unsigned BAND_W  = 9;
   localparam int unsigned PWM_W   = 11;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_GAIN      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_DEADBAND = 1'd1;
   localparam logic [GAIN_W-1:0]    STEER_GAIN_RESET    = 7'd15;
   localparam logic [BAND_W-1:0]    DEADBAND_RESET      = 9'd30;

   // stick gesture and switch thresholds
   localparam logic [PULSE_W-1:0] ARM_ROLL_MIN    = 12'd1800;
   localparam logic [PULSE_W-1:0] ARM_YAW_MAX     = 12'd1150;
   localparam logic [PULSE_W-1:0] DISARM_ROLL_MIN = 12'd1950;
   localparam logic [PULSE_W-1:0] DISARM_YAW_MAX  = 12'd1050;
   localparam logic [PULSE_W-1:0] HOLD_ON_PITCH   = 12'd1930;
   localparam logic [PULSE_W-1:0] HOLD_OFF_PITCH  = 12'd1070;

   // mixing constants
   localparam logic signed [12:0] PULSE_CENTER = 13'sd1500;
   localparam logic signed [9:0]  HALF_TURN    = 10'sd180;
   localparam logic signed [9:0]  FULL_TURN    = 10'sd360;
   localparam logic signed [17:0] DRIVE_LIMIT  = 18'sd500;
   localparam logic [PWM_W-1:0]   PWM_IDLE     = 11'd1000;

   // one input word
   typedef struct packed {
      logic [PULSE_W-1:0]        rc_roll;
      logic [PULSE_W-1:0]        rc_yaw;
      logic [PULSE_W-1:0]        pitch_pulse;
      logic [PULSE_W-1:0]        throttle_pulse;
      logic signed [ANGLE_W-1:0] yaw_angle;
   } req_word_type;

   // one result word
   typedef struct packed {
      logic             armed;
      logic             hold_active;
      logic             left_reverse;
      logic [PWM_W-1:0] left_pwm;
      logic             right_reverse;
      logic [PWM_W-1:0] right_pwm;
   } rsp_word_type;

   // control state carried from tick to tick
   typedef struct packed {
      logic                      armed;
      logic                      hold;
      logic signed [ANGLE_W-1:0] held_heading;
   } ctl_state_type;

endpackage

### rtl/rhh_if.sv
// valid/ready channel interfaces for request and response words
interface rhh_req_if;
   logic                               valid;
   logic                               ready;
   logic [rhh_pkg::PULSE_W-1:0]        rc_roll;
   logic [rhh_pkg::PULSE_W-1:0]        rc_yaw;
   logic [rhh_pkg::PULSE_W-1:0]        pitch_pulse;
   logic [rhh_pkg::PULSE_W-1:0]        throttle_pulse;
   logic signed [rhh_pkg::ANGLE_W-1:0] yaw_angle;

   modport source (output valid, rc_roll, rc_yaw, pitch_pulse, throttle_pulse, yaw_angle,
                   input ready);
   modport sink   (input valid, rc_roll, rc_yaw, pitch_pulse, throttle_pulse, yaw_angle,
                   output ready);
endinterface

interface rhh_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        armed;
   logic                        hold_active;
   logic                        left_reverse;
   logic [rhh_pkg::PWM_W-1:0]   left_pwm;
   logic                        right_reverse;
   logic [rhh_pkg::PWM_W-1:0]   right_pwm;

   modport source (output valid, armed, hold_active, left_reverse, left_pwm,
                   right_reverse, right_pwm, input ready);
   modport sink   (input valid, armed, hold_active, left_reverse, left_pwm,
                   right_reverse, right_pwm, output ready);
endinterface

### rtl/rhh_mixer.sv
// arm logic, heading hold and differential mix for one tick
module rhh_mixer (
   input  rhh_pkg::req_word_type          word,
   input  rhh_pkg::ctl_state_type         state,
   input  logic [rhh_pkg::GAIN_W-1:0]     steer_gain,
   input  logic [rhh_pkg::BAND_W-1:0]     center_deadband,
   output rhh_pkg::ctl_state_type         state_next,
   output rhh_pkg::rsp_word_type          result
);

   logic                 arm_gesture;
   logic                 disarm_gesture;
   logic                 armed_mid;
   logic                 armed_out;
   logic                 hold_mid;
   logic signed [8:0]    held_mid;
   logic signed [12:0]   roll_dev;
   logic [11:0]          roll_mag;
   logic                 centered;
   logic signed [9:0]    err_raw;
   logic signed [9:0]    err;
   logic signed [16:0]   correction;
   logic signed [16:0]   steer_dev;
   logic signed [16:0]   half;
   logic signed [17:0]   thr_dev;
   logic signed [17:0]   left_raw;
   logic signed [17:0]   right_raw;
   logic signed [17:0]   left_cl;
   logic signed [17:0]   right_cl;
   logic [8:0]           left_mag;
   logic [8:0]           right_mag;

   // arm and disarm gestures
   always_comb begin
      arm_gesture    = (word.rc_roll > rhh_pkg::ARM_ROLL_MIN) &&
                       (word.rc_yaw < rhh_pkg::ARM_YAW_MAX);
      disarm_gesture = (word.rc_roll > rhh_pkg::DISARM_ROLL_MIN) &&
                       (word.rc_yaw < rhh_pkg::DISARM_YAW_MAX);
      armed_mid      = state.armed | arm_gesture;
      armed_out      = armed_mid & ~disarm_gesture;
   end

   // hold switch on the pitch stick
   always_comb begin
      hold_mid = state.hold;
      held_mid = state.held_heading;
      if (armed_mid) begin
         priority if (word.pitch_pulse >= rhh_pkg::HOLD_ON_PITCH) begin
            hold_mid = 1'b1;
            held_mid = word.yaw_angle;
         end else if (word.pitch_pulse < rhh_pkg::HOLD_OFF_PITCH) begin
            hold_mid = 1'b0;
         end else begin
            hold_mid = state.hold;
         end
      end
   end

   // roll centering test
   always_comb begin
      roll_dev = $signed({1'b0, word.rc_roll}) - rhh_pkg::PULSE_CENTER;
      roll_mag = roll_dev[12] ? 12'(-roll_dev) : roll_dev[11:0];
      centered = roll_mag < {3'b000, center_deadband};
   end

   // wrapped heading error times gain
   always_comb begin
      err_raw = 10'(held_mid) - 10'(word.yaw_angle);
      priority if (err_raw > rhh_pkg::HALF_TURN) begin
         err = err_raw - rhh_pkg::FULL_TURN;
      end else if (err_raw < -rhh_pkg::HALF_TURN) begin
         err = err_raw + rhh_pkg::FULL_TURN;
      end else begin
         err = err_raw;
      end
      correction = $signed({10'd0, steer_gain}) * $signed({{7{err[9]}}, err});
   end

   // steering source and next control state
   always_comb begin
      state_next.armed        = armed_out;
      state_next.hold         = hold_mid;
      state_next.held_heading = held_mid;
      steer_dev               = 17'(roll_dev);
      if (armed_mid && hold_mid) begin
         if (centered) begin
            steer_dev = correction;
         end else begin
            state_next.held_heading = word.yaw_angle;
         end
      end
   end

   // halve toward zero, mix and clamp
   always_comb begin
      half      = (steer_dev + $signed({16'd0, steer_dev[16]})) >>> 1;
      thr_dev   = 18'($signed({1'b0, word.throttle_pulse}) - rhh_pkg::PULSE_CENTER);
      left_raw  = thr_dev + 18'(half);
      right_raw = thr_dev - 18'(half);
      priority if (left_raw > rhh_pkg::DRIVE_LIMIT) begin
         left_cl = rhh_pkg::DRIVE_LIMIT;
      end else if (left_raw < -rhh_pkg::DRIVE_LIMIT) begin
         left_cl = -rhh_pkg::DRIVE_LIMIT;
      end else begin
         left_cl = left_raw;
      end
      priority if (right_raw > rhh_pkg::DRIVE_LIMIT) begin
         right_cl = rhh_pkg::DRIVE_LIMIT;
      end else if (right_raw < -rhh_pkg::DRIVE_LIMIT) begin
         right_cl = -rhh_pkg::DRIVE_LIMIT;
      end else begin
         right_cl = right_raw;
      end
      left_mag  = left_cl[17]  ? 9'(-left_cl)  : left_cl[8:0];
      right_mag = right_cl[17] ? 9'(-right_cl) : right_cl[8:0];
   end

   // output word, idle drive when disarmed
   always_comb begin
      result.armed       = armed_out;
      result.hold_active = hold_mid;
      if (armed_out) begin
         result.left_reverse  = left_cl[17];
         result.left_pwm      = rhh_pkg::PWM_IDLE + {1'b0, left_mag, 1'b0};
         result.right_reverse = right_cl[17];
         result.right_pwm     = rhh_pkg::PWM_IDLE + {1'b0, right_mag, 1'b0};
      end else begin
         result.left_reverse  = 1'b0;
         result.left_pwm      = rhh_pkg::PWM_IDLE;
         result.right_reverse = 1'b0;
         result.right_pwm     = rhh_pkg::PWM_IDLE;
      end
   end

endmodule

### rtl/rover_heading_hold_motor_mixer.sv
// top level: input register, mixer, state and result register
//
// Differential drive mixer with heading hold. One request word per control
// tick carries the four RC pulse widths and the measured yaw angle; one
// response word comes back per request with the armed and hold flags and a
// direction bit and PWM value for the left and right motor pairs.
// The csr port writes steer_gain (index 0) and center_deadband (index 1)
// on any clock with csr_write_en high; write them only while no word is
// in flight.
// A request word is captured in the input register, the mixer works on it
// and the result is captured in the output register, where rsp_if.valid
// shows it. Throughput is one word per cycle while the receiver keeps up;
// the arm, hold and held heading state updates as a word moves from the
// input register to the output register, so the next word sees it at once.
// Reset disarms, clears hold, zeroes the held heading, loads the register
// defaults (gain 15, deadband 30) and empties both registers.
// When the receiver stalls the result holds in the output register, the
// input register still takes one more word, and req_if.ready then drops
// until the output register frees up.
module rover_heading_hold_motor_mixer (
   input  logic                              clock,
   input  logic                              reset,
   rhh_req_if.sink                           req_if,
   rhh_rsp_if.source                         rsp_if,
   input  logic                              csr_write_en,
   input  logic [rhh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rhh_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   rhh_pkg::req_word_type         s1_word_ff;
   rhh_pkg::req_word_type         req_word;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   rhh_pkg::rsp_word_type         out_word_ff;
   rhh_pkg::rsp_word_type         mix_word;
   rhh_pkg::ctl_state_type        state_ff;
   rhh_pkg::ctl_state_type        state_in;
   logic [rhh_pkg::GAIN_W-1:0]    steer_gain_ff;
   logic [rhh_pkg::BAND_W-1:0]    deadband_ff;
   logic                          out_open;
   logic                          s1_move;
   logic                          req_take;

   // handshake
   always_comb begin
      out_open     = ~out_valid_ff | rsp_if.ready;
      s1_move      = s1_valid_ff & out_open;
      req_if.ready = ~s1_valid_ff | out_open;
      req_take     = req_if.valid & req_if.ready;
      s1_valid_in  = req_take | (s1_valid_ff & ~s1_move);
      out_valid_in = out_open ? s1_valid_ff : out_valid_ff;
   end

   // gather the request word
   always_comb begin
      req_word.rc_roll        = req_if.rc_roll;
      req_word.rc_yaw         = req_if.rc_yaw;
      req_word.pitch_pulse    = req_if.pitch_pulse;
      req_word.throttle_pulse = req_if.throttle_pulse;
      req_word.yaw_angle      = req_if.yaw_angle;
   end

   rhh_mixer u_mixer (
      .word            (s1_word_ff),
      .state           (state_ff),
      .steer_gain      (steer_gain_ff),
      .center_deadband (deadband_ff),
      .state_next      (state_in),
      .result          (mix_word)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_move) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_word;
      end
      if (s1_move) begin
         out_word_ff <= mix_word;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         steer_gain_ff <= rhh_pkg::STEER_GAIN_RESET;
         deadband_ff   <= rhh_pkg::DEADBAND_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            rhh_pkg::CSR_STEER_GAIN: begin
               steer_gain_ff <= csr_wdata[rhh_pkg::GAIN_W-1:0];
            end
            rhh_pkg::CSR_CENTER_DEADBAND: begin
               deadband_ff <= csr_wdata[rhh_pkg::BAND_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // response port
   always_comb begin
      rsp_if.valid         = out_valid_ff;
      rsp_if.armed         = out_word_ff.armed;
      rsp_if.hold_active   = out_word_ff.hold_active;
      rsp_if.left_reverse  = out_word_ff.left_reverse;
      rsp_if.left_pwm      = out_word_ff.left_pwm;
      rsp_if.right_reverse = out_word_ff.right_reverse;
      rsp_if.right_pwm     = out_word_ff.right_pwm;
   end

endmodule

### rtl/rhh_checker.sv
// port-level checks for the motor mixer, bound to the top level
module rhh_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        armed,
   input logic                        left_reverse,
   input logic [rhh_pkg::PWM_W-1:0]   left_pwm,
   input logic                        right_reverse,
   input logic [rhh_pkg::PWM_W-1:0]   right_pwm
);

   // no response word right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // stalled word stays valid
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // stalled word holds its drive fields
   a_word_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(left_pwm) && $stable(right_pwm))
      else $error("response word changed while stalled");

   // disarmed words idle both motor pairs
   a_disarmed_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !armed |-> left_pwm == rhh_pkg::PWM_IDLE &&
      right_pwm == rhh_pkg::PWM_IDLE && !left_reverse && !right_reverse)
      else $error("disarmed word drives the motors");

   // pwm stays even and within the drive range
   a_pwm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> left_pwm >= 11'd1000 && left_pwm <= 11'd2000 && !left_pwm[0] &&
      right_pwm >= 11'd1000 && right_pwm <= 11'd2000 && !right_pwm[0])
      else $error("pwm out of range");

endmodule

bind rover_heading_hold_motor_mixer rhh_checker u_rhh_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .armed         (rsp_if.armed),
   .left_reverse  (rsp_if.left_reverse),
   .left_pwm      (rsp_if.left_pwm),
   .right_reverse (rsp_if.right_reverse),
   .right_pwm     (rsp_if.right_pwm)
);
